[src/bsc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_pkg: shared types and constants for the barometric compensation block
// Payload structs, register indexes and compensation constants.
// ----------------------------------------------------------------------------
package bsc_pkg;

  typedef struct packed {
    logic        func;
    logic [23:0] raw_sample;
  } in_item_t;

  typedef struct packed {
    logic               kind;
    logic signed [31:0] value;
    logic               div_by_zero;
  } out_item_t;

  localparam int unsigned AddrW = 6;

  localparam logic [2:0] RegAcFirst  = 3'd0;
  localparam logic [2:0] RegAcSecond = 3'd1;
  localparam logic [2:0] RegBPair    = 3'd2;
  localparam logic [2:0] RegMPair    = 3'd3;
  localparam logic [2:0] RegOss      = 3'd4;

  localparam logic [31:0] B6Offset = 32'd4000;
  localparam logic [31:0] B7Scale  = 32'd50000;
  localparam logic [31:0] B4Bias   = 32'd32768;
  localparam logic [31:0] FitSq    = 32'd3038;
  localparam logic [31:0] FitLin   = 32'hFFFF_E343; // -7357
  localparam logic [31:0] FitOfs   = 32'd3791;

  // Divider request/response
  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quot;
  } div_rsp_t;

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

endpackage

[src/bsc_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_div: unsigned 32-bit restoring divider
// One quotient bit a cycle while busy, done flagged the cycle after the last bit.
// ----------------------------------------------------------------------------
module bsc_div
  import bsc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [31:0] rem_q, rem_d, quo_q, quo_d, dvs_q, dvs_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [32:0] trial;

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quo_q[31]} - {1'b0, dvs_q};
    if (req_i.start) begin
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // shift in one dividend bit, subtract when it fits
      if (!trial[32]) begin
        rem_d = trial[31:0];
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = {rem_q[30:0], quo_q[31]};
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;

endmodule

[src/bsc_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_regs: APB configuration registers
// Calibration coefficients and oversampling setting, 64-bit data port.
// ----------------------------------------------------------------------------
module bsc_regs
  import bsc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [63:0]      pwdata,
  output logic [63:0]      prdata,
  output logic [47:0]      ac_first_o,
  output logic [47:0]      ac_second_o,
  output logic [31:0]      b_pair_o,
  output logic [31:0]      m_pair_o,
  output logic [1:0]       oss_o
);

  logic [47:0] ac1_q, ac2_q;
  logic [31:0] bp_q, mp_q;
  logic [1:0]  oss_q;
  logic [2:0]  idx;
  logic        wr;

  assign idx = paddr[5:3];
  assign wr  = psel && penable && pwrite && (paddr[2:0] == 3'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ac1_q <= '0;
      ac2_q <= '0;
      bp_q  <= '0;
      mp_q  <= '0;
      oss_q <= '0;
    end else if (wr) begin
      unique case (idx)
        RegAcFirst:  ac1_q <= pwdata[47:0];
        RegAcSecond: ac2_q <= pwdata[47:0];
        RegBPair:    bp_q  <= pwdata[31:0];
        RegMPair:    mp_q  <= pwdata[31:0];
        RegOss:      oss_q <= pwdata[1:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegAcFirst:  prdata = {16'd0, ac1_q};
      RegAcSecond: prdata = {16'd0, ac2_q};
      RegBPair:    prdata = {32'd0, bp_q};
      RegMPair:    prdata = {32'd0, mp_q};
      RegOss:      prdata = {62'd0, oss_q};
      default:     prdata = '0;
    endcase
  end

  assign ac_first_o  = ac1_q;
  assign ac_second_o = ac2_q;
  assign b_pair_o    = bp_q;
  assign m_pair_o    = mp_q;
  assign oss_o       = oss_q;

endmodule

[src/baro_sensor_compensation.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// baro_sensor_compensation: integer temperature/pressure compensation
// Sequencer around one shared multiplier and one serial divider.
// ----------------------------------------------------------------------------
// Each input transaction carries a raw temperature or pressure reading. A
// temperature transaction computes B5 from the calibration coefficients, keeps
// it, and returns the temperature in 0.1 degree steps saturated to 16 bits.
// A pressure transaction returns pascals using the kept B5 (zero after reset).
// A zero divisor returns 0 with div_by_zero set. All arithmetic wraps at 32
// bits. One shared 32x32 multiplier (one product per cycle) and one bit-serial
// 32-bit divider carry the work under a sequencer. out_valid_o is high while
// the result is held in StOut; a zero divisor skips the divider. The block
// takes one transaction at a time; in_ready_o is low from acceptance until
// the result has been taken.
// Configuration is written over APB at byte address 8*index, 64-bit data;
// write only while idle.
// ----------------------------------------------------------------------------
module baro_sensor_compensation
  import bsc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_item_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_item_t        out_data_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [63:0]      pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);

  typedef enum logic [22:0] {
    StIdle  = 23'h000001,
    StT1    = 23'h000002, // (ut-ac6)*ac5
    StT2    = 23'h000004, // x1
    StTDiv  = 23'h000008, // wait for quotient, b5, temp out
    StT3    = 23'h000010, // den, divide start
    StP1    = 23'h000020, // b6*b6
    StP2    = 23'h000040, // b2*sq
    StP3    = 23'h000080, // ac2*b6
    StP4    = 23'h000100, // ac3*b6
    StP5    = 23'h000200, // b1*sq
    StP6    = 23'h000400, // ac4*(x3+bias)
    StP7    = 23'h000800, // (up-b3)*scale
    StPDiv  = 23'h001000,
    StP8    = 23'h002000, // b4 check, divide start
    StP9    = 23'h004000, // (p>>8)^2
    StP10   = 23'h008000, // x1*3038
    StP11   = 23'h010000, // -7357*p, final sum
    StOut   = 23'h020000
  } state_e;

  state_e      state_q, state_d;
  logic [47:0] ac_first, ac_second;
  logic [31:0] b_pair, m_pair;
  logic [1:0]  oss;

  in_item_t    item_q;
  logic [31:0] b5_q, b5_d;
  logic [31:0] a_q, a_d, b_q, b_d, c_q, c_d, d_q, d_d, e_q, e_d;
  logic        neg_q, neg_d, big_q, big_d;
  out_item_t   out_q, out_d;

  // Shared multiplier operands and registered product
  logic [31:0] mul_a, mul_b, prod_q;
  div_req_t    dreq;
  div_rsp_t    drsp;

  bsc_regs u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata,
    .ac_first_o(ac_first), .ac_second_o(ac_second),
    .b_pair_o(b_pair), .m_pair_o(m_pair), .oss_o(oss)
  );

  bsc_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  assign pready = 1'b1;

  // Coefficient fields
  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md, up, ut;
  assign ac1 = sx16(ac_first[47:32]);
  assign ac2 = sx16(ac_first[31:16]);
  assign ac3 = sx16(ac_first[15:0]);
  assign ac4 = {16'd0, ac_second[47:32]};
  assign ac5 = {16'd0, ac_second[31:16]};
  assign ac6 = {16'd0, ac_second[15:0]};
  assign b1  = sx16(b_pair[31:16]);
  assign b2  = sx16(b_pair[15:0]);
  assign mc  = sx16(m_pair[31:16]);
  assign md  = sx16(m_pair[15:0]);
  assign ut  = {16'd0, item_q.raw_sample[15:0]};
  assign up  = {8'd0, item_q.raw_sample} >> (4'd8 - {2'd0, oss});

  // Arithmetic right shift of a 32-bit value
  function automatic logic [31:0] asr(input logic [31:0] x, input logic [4:0] n);
    return 32'($signed(x) >>> n);
  endfunction

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  logic [31:0] den, b3, sres, pfin, b7, x3t, abs_q;
  logic [31:0] tsat;

  always_comb begin
    state_d = state_q;
    b5_d = b5_q;
    a_d = a_q; b_d = b_q; c_d = c_q; d_d = d_q; e_d = e_q;
    neg_d = neg_q; big_d = big_q;
    out_d = out_q;
    mul_a = '0;
    mul_b = '0;
    dreq  = '0;
    den   = a_q + md;
    b3    = '0; sres = '0; pfin = '0; b7 = '0; x3t = '0; tsat = '0;
    abs_q = neg_q ? (32'd0 - drsp.quot) : drsp.quot;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) state_d = in_data_i.func ? StP1 : StT1;
      end
      StT1: begin
        mul_a = ut - ac6; mul_b = ac5;
        state_d = StT2;
      end
      StT2: begin
        a_d = asr(prod_q, 5'd15); // x1
        state_d = StT3;
      end
      StT3: begin
        // start divide of mc<<11 by den, or flag div_by_zero when den is zero
        if (den == 32'd0) begin
          b5_d = a_q;
          out_d = '{kind: 1'b0, value: 32'sd0, div_by_zero: 1'b1};
          state_d = StOut;
        end else begin
          b_d = mc << 11;
          neg_d = (b_d[31] != den[31]);
          dreq.start = 1'b1;
          dreq.dividend = b_d[31] ? (32'd0 - b_d) : b_d;
          dreq.divisor  = den[31] ? (32'd0 - den) : den;
          state_d = StTDiv;
        end
      end
      StTDiv: begin
        if (drsp.done) begin
          b5_d = a_q + abs_q;
          sres = asr(a_q + abs_q + 32'd8, 5'd4);
          if ($signed(sres) > 32'sd32767) tsat = 32'd32767;
          else if ($signed(sres) < -32'sd32768) tsat = 32'hFFFF_8000;
          else tsat = sres;
          out_d = '{kind: 1'b0, value: tsat, div_by_zero: 1'b0};
          state_d = StOut;
        end
      end
      StP1: begin
        a_d = b5_q - B6Offset; // b6
        mul_a = b5_q - B6Offset; mul_b = b5_q - B6Offset;
        state_d = StP2;
      end
      StP2: begin
        b_d = asr(prod_q, 5'd12); // sq
        mul_a = b2; mul_b = asr(prod_q, 5'd12);
        state_d = StP3;
      end
      StP3: begin
        c_d = asr(prod_q, 5'd11); // x1
        mul_a = ac2; mul_b = a_q;
        state_d = StP4;
      end
      StP4: begin
        // b3 = ((ac1*4 + x3) << oss + 2) / 4, truncating toward zero
        b3 = (((ac1 << 2) + c_q + asr(prod_q, 5'd11)) << oss) + 32'd2;
        c_d = asr(b3, 5'd2) + {31'd0, b3[31] && (b3[1:0] != 2'd0)};
        mul_a = ac3; mul_b = a_q;
        state_d = StP5;
      end
      StP5: begin
        d_d = asr(prod_q, 5'd13);
        mul_a = b1; mul_b = b_q;
        state_d = StP6;
      end
      StP6: begin
        x3t = asr(d_q + asr(prod_q, 5'd16) + 32'd2, 5'd2);
        mul_a = ac4; mul_b = x3t + B4Bias;
        state_d = StP7;
      end
      StP7: begin
        e_d = prod_q >> 15; // b4
        mul_a = up - c_q; mul_b = B7Scale >> oss;
        state_d = StP8;
      end
      StP8: begin
        if (e_q == 32'd0) begin
          out_d = '{kind: 1'b1, value: 32'sd0, div_by_zero: 1'b1};
          state_d = StOut;
        end else begin
          b7 = prod_q;
          big_d = b7[31];
          dreq.start = 1'b1;
          dreq.dividend = b7[31] ? b7 : (b7 << 1);
          dreq.divisor = e_q;
          state_d = StPDiv;
        end
      end
      StPDiv: begin
        if (drsp.done) begin
          a_d = big_q ? (drsp.quot << 1) : drsp.quot; // p
          state_d = StP9;
        end
      end
      StP9: begin
        mul_a = asr(a_q, 5'd8); mul_b = asr(a_q, 5'd8);
        state_d = StP10;
      end
      StP10: begin
        mul_a = prod_q; mul_b = FitSq;
        state_d = StP11;
      end
      StP11: begin
        b_d = asr(prod_q, 5'd16);
        mul_a = FitLin; mul_b = a_q;
        state_d = StP11;
        // wait for the -7357*p product; reuse neg_q as phase
        if (neg_q) begin
          pfin = a_q + asr(b_q + asr(prod_q, 5'd16) + FitOfs, 5'd4);
          out_d = '{kind: 1'b1, value: pfin, div_by_zero: 1'b0};
          neg_d = 1'b0;
          state_d = StOut;
        end else begin
          neg_d = 1'b1;
        end
      end
      StOut: begin
        if (out_ready_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
    if (state_q == StP9) neg_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      b5_q    <= '0;
    end else begin
      state_q <= state_d;
      b5_q    <= b5_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && in_valid_i) item_q <= in_data_i;
    a_q <= a_d; b_q <= b_d; c_q <= c_d; d_q <= d_d; e_q <= e_d;
    neg_q <= neg_d; big_q <= big_d;
    out_q <= out_d;
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = (state_q == StOut);
  assign out_data_o  = out_q;

endmodule
